FILE: rtl/xetd_pkg.sv
// Package of the XML entity text decoder: codes, state types and the fallback text.
package xetd_pkg;

   localparam int MAX_UNITS = 64;
   localparam int UNITS_W   = $clog2(MAX_UNITS + 1);

   localparam logic [7:0] BYTE_C3     = 8'hC3;
   localparam logic [7:0] BYTE_C5     = 8'hC5;
   localparam logic [7:0] BYTE_AMP    = 8'h26;
   localparam logic [7:0] BYTE_ZERO   = 8'h30;
   localparam logic [7:0] BYTE_SPACE  = 8'h20;
   localparam logic [7:0] BYTE_PERIOD = 8'h2E;
   localparam logic [7:0] BYTE_COMMA  = 8'h2C;
   localparam logic [7:0] BYTE_UNDER  = 8'h5F;
   localparam logic [7:0] BYTE_L      = 8'h6C;
   localparam logic [7:0] BYTE_G      = 8'h67;
   localparam logic [7:0] BYTE_A      = 8'h61;
   localparam logic [7:0] BYTE_P      = 8'h70;
   localparam logic [7:0] BYTE_Q      = 8'h71;
   localparam logic [7:0] BYTE_HASH   = 8'h23;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_APOS   = 8'h27;
   localparam logic [7:0] CHAR_QUOT   = 8'h22;
   localparam logic [7:0] SUPPRESS_CODE = 8'd194;
   localparam logic [7:0] C3_OFFSET   = 8'd64;

   localparam logic [2:0] UNKNOWN_LEN  = 3'd7;
   localparam logic [2:0] UNKNOWN_LAST = 3'd6;

   localparam logic CSR_SKIP_LEADING = 1'b0;

   typedef enum logic [7:0] {
      PH_IDLE  = 8'b0000_0001,
      PH_C3    = 8'b0000_0010,
      PH_C5    = 8'b0000_0100,
      PH_AMP1  = 8'b0000_1000,
      PH_AMPA  = 8'b0001_0000,
      PH_SKIPN = 8'b0010_0000,
      PH_DIGIT = 8'b0100_0000,
      PH_DONE  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [UNITS_W-1:0] units;
      logic               emit;
   } start_type;

   function automatic logic [7:0] unknown_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h75;
         3'd1:    c = 8'h6E;
         3'd2:    c = 8'h6B;
         3'd3:    c = 8'h6E;
         3'd4:    c = 8'h6F;
         3'd5:    c = 8'h77;
         3'd6:    c = 8'h6E;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/xml_entity_text_decoder.sv
// Top level of the XML entity text decoder: byte stream in, decoded characters out.
//
// The request channel carries one word per cycle while req_ready is high: a byte
// of the encoded string (req_in_byte) or an end word (req_in_end) that closes the
// string. Each word is decoded in the cycle it is accepted against the running
// string state, and the results it causes are loaded into a result register. The
// response channel then presents them one word per cycle while rsp_ready is high:
// a decoded character with rsp_has_char set, or the end word with rsp_out_end set.
// The first response word is presented in the cycle after its request is accepted.
// A word that causes at most one result sustains one word per cycle while
// rsp_ready is high; a word that causes more holds the request side until the
// result register has drained its last response word (at most 2 results, and 7
// for the text of a lone zero string).
// Under a response stall the result register holds and req_ready stays low until
// its last word is taken. Synchronous reset clears the string state, empties the
// result register and sets skip_leading to 0. The APB port holds skip_leading at
// byte address 0.
module xml_entity_text_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_has_char,
   output logic        rsp_out_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import xetd_pkg::*;

   function automatic start_type start_unit(input logic [7:0] b,
                                            input logic [UNITS_W-1:0] units);
      start_type r;
      r.units = units;
      r.emit  = 1'b0;
      r.phase = PH_IDLE;
      if (units >= UNITS_W'(MAX_UNITS)) begin
         r.phase = PH_DONE;
      end else begin
         r.units = units + 1'b1;
         case (b)
            BYTE_C3:  r.phase = PH_C3;
            BYTE_C5:  r.phase = PH_C5;
            BYTE_AMP: r.phase = PH_AMP1;
            default: begin
               r.phase = PH_IDLE;
               r.emit  = 1'b1;
            end
         endcase
      end
      return r;
   endfunction

   logic               skip_leading_ff;
   phase_type          phase_ff, phase_in;
   logic [2:0]         skip_ff, skip_in;
   logic [7:0]         ent_ff, ent_in;
   logic [7:0]         digit_ff, digit_in;
   logic               suppress_ff, suppress_in;
   logic               at_start_ff, at_start_in;
   logic               zero_ff, zero_in;
   logic [UNITS_W-1:0] units_ff, units_in;

   logic               pk_valid_ff;
   logic [2:0]         pk_pos_ff;
   logic [2:0]         pk_cnt_ff;
   logic               pk_unk_ff;
   logic [1:0]         pk_nch_ff;
   logic [7:0]         pk_c0_ff;
   logic [7:0]         pk_c1_ff;

   logic [7:0]         ch_buf [2];
   logic [1:0]         nch;
   logic               res_end;
   logic               res_unk;
   logic [2:0]         res_cnt;

   logic               req_take;
   logic               rsp_take;
   logic               pk_last;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_SKIP_LEADING) ? {31'd0, skip_leading_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_leading_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr[2] == CSR_SKIP_LEADING) begin
         skip_leading_ff <= pwdata[0];
      end
   end

   always_comb begin
      start_type  su;
      logic [7:0] b;
      b           = req_in_byte;
      su          = '0;
      phase_in    = phase_ff;
      skip_in     = skip_ff;
      ent_in      = ent_ff;
      digit_in    = digit_ff;
      suppress_in = suppress_ff;
      at_start_in = at_start_ff;
      zero_in     = zero_ff;
      units_in    = units_ff;
      ch_buf[0]   = 8'd0;
      ch_buf[1]   = 8'd0;
      nch         = 2'd0;
      res_end     = 1'b0;
      res_unk     = 1'b0;
      if (req_in_end) begin
         if (zero_ff) begin
            res_unk = 1'b1;
         end else begin
            if (phase_ff == PH_AMP1 && !suppress_ff) begin
               ch_buf[0] = BYTE_AMP;
               nch       = 2'd1;
            end
            res_end = 1'b1;
         end
         phase_in    = PH_IDLE;
         skip_in     = 3'd0;
         ent_in      = 8'd0;
         digit_in    = 8'd0;
         suppress_in = 1'b0;
         at_start_in = 1'b1;
         zero_in     = 1'b0;
         units_in    = '0;
      end else if (at_start_ff) begin
         if (!(skip_leading_ff && (b == BYTE_SPACE || b == BYTE_PERIOD ||
                                   b == BYTE_COMMA || b == BYTE_UNDER))) begin
            at_start_in = 1'b0;
            if (b == BYTE_ZERO) begin
               zero_in = 1'b1;
            end else begin
               su       = start_unit(b, units_ff);
               phase_in = su.phase;
               units_in = su.units;
               if (su.emit && !suppress_ff) begin
                  ch_buf[0] = b;
                  nch       = 2'd1;
               end
            end
         end
      end else begin
         if (zero_ff) begin
            zero_in  = 1'b0;
            su       = start_unit(BYTE_ZERO, units_in);
            phase_in = su.phase;
            units_in = su.units;
            if (su.emit && !suppress_ff) begin
               ch_buf[nch[0]] = BYTE_ZERO;
               nch            = nch + 2'd1;
            end
         end
         case (phase_in)
            PH_IDLE: begin
               su       = start_unit(b, units_in);
               phase_in = su.phase;
               units_in = su.units;
               if (su.emit && !suppress_ff) begin
                  ch_buf[nch[0]] = b;
                  nch            = nch + 2'd1;
               end
            end
            PH_C3: begin
               ch_buf[nch[0]] = b + C3_OFFSET;
               nch            = nch + 2'd1;
               phase_in       = PH_IDLE;
            end
            PH_C5: begin
               phase_in = PH_IDLE;
            end
            PH_AMP1: begin
               case (b)
                  BYTE_L: begin
                     ent_in   = CHAR_LT;
                     skip_in  = 3'd2;
                     phase_in = PH_SKIPN;
                  end
                  BYTE_G: begin
                     ent_in   = CHAR_GT;
                     skip_in  = 3'd2;
                     phase_in = PH_SKIPN;
                  end
                  BYTE_A: begin
                     phase_in = PH_AMPA;
                  end
                  BYTE_Q: begin
                     ent_in   = CHAR_QUOT;
                     skip_in  = 3'd4;
                     phase_in = PH_SKIPN;
                  end
                  BYTE_HASH: begin
                     digit_in = 8'd0;
                     skip_in  = 3'd3;
                     phase_in = PH_DIGIT;
                  end
                  default: begin
                     if (!suppress_ff) begin
                        ch_buf[nch[0]] = BYTE_AMP;
                        nch            = nch + 2'd1;
                     end
                     su       = start_unit(b, units_in);
                     phase_in = su.phase;
                     units_in = su.units;
                     if (su.emit && !suppress_ff) begin
                        ch_buf[nch[0]] = b;
                        nch            = nch + 2'd1;
                     end
                  end
               endcase
            end
            PH_AMPA: begin
               ent_in   = (b == BYTE_P) ? CHAR_APOS : BYTE_AMP;
               skip_in  = (b == BYTE_P) ? 3'd3 : 3'd2;
               phase_in = PH_SKIPN;
            end
            PH_SKIPN: begin
               skip_in = skip_ff - 3'd1;
               if (skip_in == 3'd0) begin
                  phase_in = PH_IDLE;
                  if (ent_ff == SUPPRESS_CODE) begin
                     suppress_in = ~suppress_ff;
                  end else if (!suppress_ff) begin
                     ch_buf[nch[0]] = ent_ff;
                     nch            = nch + 2'd1;
                  end
               end
            end
            PH_DIGIT: begin
               digit_in = {digit_ff[4:0], 3'b000} + {digit_ff[6:0], 1'b0} + b - BYTE_ZERO;
               skip_in  = skip_ff - 3'd1;
               if (skip_in == 3'd0) begin
                  ent_in   = digit_in;
                  skip_in  = 3'd1;
                  phase_in = PH_SKIPN;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
      res_cnt = res_unk ? UNKNOWN_LEN : ({1'b0, nch} + {2'b00, res_end});
   end

   assign pk_last  = (pk_pos_ff == pk_cnt_ff - 3'd1);
   assign rsp_take = pk_valid_ff && rsp_ready;
   assign req_ready = !pk_valid_ff || (rsp_ready && pk_last);
   assign req_take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         skip_ff     <= 3'd0;
         ent_ff      <= 8'd0;
         digit_ff    <= 8'd0;
         suppress_ff <= 1'b0;
         at_start_ff <= 1'b1;
         zero_ff     <= 1'b0;
         units_ff    <= '0;
      end else if (req_take) begin
         phase_ff    <= phase_in;
         skip_ff     <= skip_in;
         ent_ff      <= ent_in;
         digit_ff    <= digit_in;
         suppress_ff <= suppress_in;
         at_start_ff <= at_start_in;
         zero_ff     <= zero_in;
         units_ff    <= units_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pk_valid_ff <= 1'b0;
         pk_pos_ff   <= 3'd0;
      end else if (req_take) begin
         pk_valid_ff <= (res_cnt != 3'd0);
         pk_pos_ff   <= 3'd0;
      end else if (rsp_take) begin
         if (pk_last) begin
            pk_valid_ff <= 1'b0;
         end else begin
            pk_pos_ff <= pk_pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pk_cnt_ff <= res_cnt;
         pk_unk_ff <= res_unk;
         pk_nch_ff <= nch;
         pk_c0_ff  <= ch_buf[0];
         pk_c1_ff  <= ch_buf[1];
      end
   end

   assign rsp_valid = pk_valid_ff;

   always_comb begin
      if (pk_unk_ff) begin
         rsp_out_byte = unknown_char(pk_pos_ff);
         rsp_has_char = 1'b1;
         rsp_out_end  = (pk_pos_ff == UNKNOWN_LAST);
      end else if (pk_pos_ff < {1'b0, pk_nch_ff}) begin
         rsp_out_byte = pk_pos_ff[0] ? pk_c1_ff : pk_c0_ff;
         rsp_has_char = 1'b1;
         rsp_out_end  = 1'b0;
      end else begin
         rsp_out_byte = 8'd0;
         rsp_has_char = 1'b0;
         rsp_out_end  = 1'b1;
      end
   end

endmodule

FILE: verif/xetd_text_checker.sv
`timescale 1ns / 1ps
// Checker for the XML entity text decoder: predicts the decoded words and compares responses.
module xetd_text_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_end,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_has_char,
   input  logic        rsp_out_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending,
   output int          results_checked
);
   import xetd_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       last;
   } text_word_type;

   localparam int          FALLBACK_LEN  = 7;
   localparam logic [55:0] FALLBACK_TEXT = "unknown";
   localparam logic [2:0]  CSR_ADDR_SKIP = {CSR_SKIP_LEADING, 2'b00};

   text_word_type      expected_text[$];
   logic               skip_cfg;
   phase_type          phase;
   logic [2:0]         skip_count;
   logic [7:0]         ent_char;
   logic [7:0]         num_value;
   logic               mute;
   logic               at_head;
   logic               zero_wait;
   logic [UNITS_W-1:0] units;
   int                 fails = 0;
   int                 checked = 0;

   task automatic push_word(input logic [7:0] ch, input logic has, input logic last);
      text_word_type w;
      w.ch       = ch;
      w.has_char = has;
      w.last     = last;
      expected_text.push_back(w);
   endtask

   task automatic emit_visible(input logic [7:0] ch);
      if (!mute) push_word(ch, 1'b1, 1'b0);
   endtask

   task automatic clear_string();
      phase      = PH_IDLE;
      skip_count = '0;
      ent_char   = '0;
      num_value  = '0;
      mute       = 1'b0;
      at_head    = 1'b1;
      zero_wait  = 1'b0;
      units      = '0;
   endtask

   task automatic open_unit(input logic [7:0] b);
      if (units >= MAX_UNITS) begin
         phase = PH_DONE;
      end else begin
         units = units + 1'b1;
         if (b == BYTE_C3) phase = PH_C3;
         else if (b == BYTE_C5) phase = PH_C5;
         else if (b == BYTE_AMP) phase = PH_AMP1;
         else begin
            phase = PH_IDLE;
            emit_visible(b);
         end
      end
   endtask

   task automatic open_entity(input logic [7:0] ch, input logic [2:0] count);
      ent_char   = ch;
      skip_count = count;
      phase      = PH_SKIPN;
   endtask

   task automatic decode_word(input logic [7:0] b, input logic last);
      logic lead;
      lead = (b == BYTE_SPACE) || (b == BYTE_PERIOD) || (b == BYTE_COMMA) || (b == BYTE_UNDER);
      if (last) begin
         if (zero_wait) begin
            for (int i = 0; i < FALLBACK_LEN; i++)
               push_word(FALLBACK_TEXT[8*(FALLBACK_LEN-1-i) +: 8], 1'b1, i == FALLBACK_LEN - 1);
         end else begin
            if (phase == PH_AMP1) emit_visible(BYTE_AMP);
            push_word(8'h00, 1'b0, 1'b1);
         end
         clear_string();
      end else if (at_head) begin
         if (!(skip_cfg && lead)) begin
            at_head = 1'b0;
            if (b == BYTE_ZERO) zero_wait = 1'b1;
            else open_unit(b);
         end
      end else begin
         if (zero_wait) begin
            zero_wait = 1'b0;
            open_unit(BYTE_ZERO);
         end
         case (phase)
            PH_IDLE: begin
               open_unit(b);
            end
            PH_C3: begin
               push_word(b + C3_OFFSET, 1'b1, 1'b0);
               phase = PH_IDLE;
            end
            PH_C5: begin
               phase = PH_IDLE;
            end
            PH_AMP1: begin
               if (b == BYTE_L) open_entity(CHAR_LT, 3'd2);
               else if (b == BYTE_G) open_entity(CHAR_GT, 3'd2);
               else if (b == BYTE_A) phase = PH_AMPA;
               else if (b == BYTE_Q) open_entity(CHAR_QUOT, 3'd4);
               else if (b == BYTE_HASH) begin
                  num_value  = '0;
                  skip_count = 3'd3;
                  phase      = PH_DIGIT;
               end else begin
                  emit_visible(BYTE_AMP);
                  phase = PH_IDLE;
                  open_unit(b);
               end
            end
            PH_AMPA: begin
               if (b == BYTE_P) open_entity(CHAR_APOS, 3'd3);
               else open_entity(BYTE_AMP, 3'd2);
            end
            PH_SKIPN: begin
               skip_count = skip_count - 3'd1;
               if (skip_count == 3'd0) begin
                  phase = PH_IDLE;
                  if (ent_char == SUPPRESS_CODE) mute = ~mute;
                  else emit_visible(ent_char);
               end
            end
            PH_DIGIT: begin
               num_value  = num_value * 8'd10 + b - BYTE_ZERO;
               skip_count = skip_count - 3'd1;
               if (skip_count == 3'd0) open_entity(num_value, 3'd1);
            end
            default: begin
               phase = PH_DONE;
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : monitor
      text_word_type want;
      if (reset) begin
         skip_cfg = 1'b0;
         clear_string();
         expected_text.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_text.size() == 0) begin
               $error("unexpected response word: out_byte %0h has_char %0b out_end %0b",
                      rsp_out_byte, rsp_has_char, rsp_out_end);
               fails++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_out_byte !== want.ch) begin
                  $error("out_byte: expected %0h, got %0h", want.ch, rsp_out_byte);
                  fails++;
               end
               if (rsp_has_char !== want.has_char) begin
                  $error("has_char: expected %0b, got %0b", want.has_char, rsp_has_char);
                  fails++;
               end
               if (rsp_out_end !== want.last) begin
                  $error("out_end: expected %0b, got %0b", want.last, rsp_out_end);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) decode_word(req_in_byte, req_in_end);
         if (psel && penable && pwrite && pready && paddr == CSR_ADDR_SKIP) skip_cfg = pwdata[0];
      end
      fail_count      <= fails;
      pending         <= expected_text.size();
      results_checked <= checked;
   end

endmodule

FILE: verif/tb_xml_entity_text_decoder.sv
`timescale 1ns / 1ps
// Testbench top of the XML entity text decoder: clock, reset, stimulus, stalls and verdict.
module tb_xml_entity_text_decoder;
   import xetd_pkg::*;

   localparam int         HOLD_CYCLES    = 80;
   localparam int         DRAIN_CYCLES   = 4;
   localparam int         QUIET_LIMIT    = 2000;
   localparam logic [2:0] CSR_ADDR_SKIP  = {CSR_SKIP_LEADING, 2'b00};
   localparam logic [2:0] CSR_ADDR_SPARE = {~CSR_SKIP_LEADING, 2'b00};

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_end  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_has_char;
   logic        rsp_out_end;
   logic        psel        = 1'b0;
   logic        penable     = 1'b0;
   logic        pwrite      = 1'b0;
   logic [2:0]  paddr       = 3'd0;
   logic [31:0] pwdata      = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int          fail_count;
   int          pending;
   int          results_checked;
   logic        no_idle      = 1'b0;
   int          holds_asked  = 0;
   int          holds_done   = 0;
   int          stall_left   = 0;
   int          quiet_cycles = 0;
   int          words_sent   = 0;
   int          strings_sent = 0;
   logic [7:0]  text[$];

   xml_entity_text_decoder i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_end   (req_in_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_char (rsp_has_char),
      .rsp_out_end  (rsp_out_end),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   xetd_text_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_in_end      (req_in_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_char    (rsp_has_char),
      .rsp_out_end     (rsp_out_end),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_span();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] lead_char();
      case ($urandom_range(0, 3))
         0:       return BYTE_SPACE;
         1:       return BYTE_PERIOD;
         2:       return BYTE_COMMA;
         default: return BYTE_UNDER;
      endcase
   endfunction

   always @(posedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         stall_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = idle_span() - 1;
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      gap = (!no_idle && $urandom_range(0, 2) == 0) ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_end  <= last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endtask

   task automatic send_text();
      foreach (text[i]) send_word(text[i], 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1);
      strings_sent++;
      text.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic add_unit();
      case ($urandom_range(0, 11))
         0, 1, 2: text.push_back(8'($urandom_range(0, 255)));
         3: begin
            text.push_back(BYTE_C3);
            text.push_back(8'($urandom_range(0, 255)));
         end
         4: begin
            text.push_back(BYTE_C5);
            text.push_back(8'($urandom_range(0, 255)));
         end
         5: begin
            case ($urandom_range(0, 4))
               0:       push_str("&lt;");
               1:       push_str("&gt;");
               2:       push_str("&amp;");
               3:       push_str("&apos;");
               default: push_str("&quot;");
            endcase
         end
         6: begin
            push_str("&#");
            repeat (3) begin
               if ($urandom_range(0, 4) == 0) text.push_back(8'($urandom_range(0, 255)));
               else text.push_back(BYTE_ZERO + 8'($urandom_range(0, 9)));
            end
            push_str(";");
         end
         7: push_str("&#194;");
         8: begin
            text.push_back(BYTE_AMP);
            text.push_back(8'($urandom_range(0, 255)));
         end
         9: text.push_back(lead_char());
         default: text.push_back(8'($urandom_range(8'h41, 8'h7A)));
      endcase
   endtask

   task automatic build_random_text();
      int pick;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text.push_back(lead_char());
      if (pick == 0) begin
         push_str("0");
      end else begin
         if (pick == 1) push_str("0");
         repeat ($urandom_range(0, 6)) add_unit();
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) if (text.size() > 0) void'(text.pop_back());
         end
      end
   endtask

   initial begin
      int         base;
      logic [31:0] word;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      push_str("0");
      send_text();
      push_str("0");
      text.push_back(BYTE_C3);
      text.push_back(8'hFF);
      send_text();
      text.push_back(BYTE_C5);
      text.push_back(8'h00);
      push_str("&x");
      send_text();
      push_str("&#194;z");
      send_text();
      push_str("&");
      send_text();
      push_str("&l");
      send_text();
      text.push_back(BYTE_C3);
      send_text();

      wait_drained();
      csr_write(CSR_ADDR_SPARE, 32'h0000_0001);
      push_str(" 0");
      send_text();
      wait_drained();
      csr_write(CSR_ADDR_SKIP, 32'h0000_0001);
      push_str(" _0");
      send_text();

      base = words_sent;
      for (int seg = 0; seg < 4; seg++) begin
         wait_drained();
         word    = $urandom();
         word[0] = seg[0];
         csr_write(CSR_ADDR_SKIP, word);
         no_idle <= (seg >= 2);
         if (seg == 3) begin
            holds_asked <= holds_asked + 1;
            push_str("0");
            send_text();
            push_str("ab&lt;c");
            send_text();
            push_str("0");
            send_text();
            no_idle <= 1'b0;
            wait_drained();
            repeat (7) push_str("abcdefghij");
            push_str("&lt;xyz");
            send_text();
         end
         while (words_sent < base + 50 * (seg + 1)) begin
            build_random_text();
            send_text();
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      $display("Covered %0d words in %0d strings, %0d response words checked.",
               words_sent, strings_sent, results_checked);
      $display("Both skip_leading settings, a long response stall and the unit limit were hit.");
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
